### src/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and the divide-by-255 helper for the HSV to RGB
// converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// Full channel level and its square
	localparam logic [7:0]  FULL_LEVEL  = 8'd255;
	localparam logic [15:0] FULL_SQ     = 16'd65025;
	// Degrees per hue sector
	localparam int unsigned SECTOR_DEG  = 60;
	localparam int unsigned SECTOR_NUM  = 6;
	// Hue sectors can reach this many before wrapping (hue up to 511)
	localparam int unsigned SECTOR_RAW_MAX = 8;

	// Hue sector, named by the colors at its start and end
	typedef enum logic [2:0] {
		SEC_RED_YELLOW,
		SEC_YELLOW_GREEN,
		SEC_GREEN_CYAN,
		SEC_CYAN_BLUE,
		SEC_BLUE_MAGENTA,
		SEC_MAGENTA_RED
	} sector_t;

	// Result of the hue split stage
	typedef struct packed {
		sector_t    sector;
		logic [7:0] frac;
	} hue_split_t;

	// floor(x / 255) for a 24-bit x below 255*65536.
	// x*257/65536 undershoots x/255 by less than one for x < 255*65536, so the
	// estimate is the quotient or one below it; one compare fixes it.
	function automatic logic [16:0] div255(input logic [23:0] x);
		logic [32:0] acc;
		logic [16:0] q0;
		logic [25:0] q0_x255;
		logic [25:0] rem;
		logic [16:0] q;
		acc     = {1'b0, x, 8'b0} + {9'b0, x};
		q0      = acc[32:16];
		q0_x255 = ({9'b0, q0} << 8) - {9'b0, q0};
		rem     = {2'b0, x} - q0_x255;
		if (rem >= 26'd255) begin
			q = q0 + 17'd1;
		end else begin
			q = q0;
		end
		return q;
	endfunction

endpackage

### src/hsv2rgb_hue_split.sv
// ----------------------------------------------------------------------------
// hsv2rgb_hue_split
// First pipeline stage: splits the hue into a 60-degree sector and a
// fraction 0..250 within it. Hue above 359 wraps round the sectors.
// ----------------------------------------------------------------------------
module hsv2rgb_hue_split (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  logic [8:0]               hue,
	output logic                     vld_s1,
	output hsv2rgb_pkg::hue_split_t  split_s1
);

	logic [3:0]  sec_raw;
	logic [8:0]  sec_base;
	logic [2:0]  sec_wrap;
	logic [5:0]  hue_rem;
	logic [9:0]  rem_x17;
	hsv2rgb_pkg::hue_split_t split_d;

	// Sector by threshold compares against multiples of 60
	always_comb begin
		sec_raw  = '0;
		sec_base = '0;
		for (int k = 1; k <= int'(hsv2rgb_pkg::SECTOR_RAW_MAX); k++) begin
			if (hue >= 9'(k * hsv2rgb_pkg::SECTOR_DEG)) begin
				sec_raw  = 4'(k);
				sec_base = 9'(k * hsv2rgb_pkg::SECTOR_DEG);
			end
		end
	end

	// Wrap sector mod 6, remainder within the sector
	always_comb begin
		if (sec_raw >= 4'(hsv2rgb_pkg::SECTOR_NUM)) begin
			sec_wrap = 3'(sec_raw - 4'(hsv2rgb_pkg::SECTOR_NUM));
		end else begin
			sec_wrap = sec_raw[2:0];
		end
		hue_rem = 6'(hue - sec_base);
	end

	// frac = rem * 255 / 60 = rem * 17 / 4
	always_comb begin
		rem_x17        = ({4'b0, hue_rem} << 4) + {4'b0, hue_rem};
		split_d.sector = hsv2rgb_pkg::sector_t'(sec_wrap);
		split_d.frac   = rem_x17[9:2];
	end

	// Stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		split_s1 <= split_d;
	end

endmodule

### src/hsv_to_rgb_8bit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_8bit
// HSV to RGB color converter, 8 bits per channel, exact integer arithmetic.
// ----------------------------------------------------------------------------
// Takes one color per clock cycle: busy is always low, so every cycle with
// start high is a transfer. The result appears on red, green and blue
// after the register stages below, marked by done for exactly one cycle;
// there is no way to hold results back, so the receiver must take each one
// when done is high. The six register stages are: hue split, three 8x8
// products, two 16x8 products with a divide of the low level by 255, then
// two divide-by-255 steps and the sector select.
// ----------------------------------------------------------------------------
module hsv_to_rgb_8bit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [8:0] hue,
	input  logic [7:0] saturation,
	input  logic [7:0] brightness,
	output logic       done,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	logic                     take;
	// Stage 1
	logic                     vld_s1;
	hsv2rgb_pkg::hue_split_t  split_s1;
	logic [7:0]               sat_s1;
	logic [7:0]               val_s1;
	// Stage 2
	logic                     vld_s2;
	hsv2rgb_pkg::sector_t     sector_s2;
	logic [7:0]               val_s2;
	logic [15:0]              fs_s2;
	logic [15:0]              gs_s2;
	logic [15:0]              ps_s2;
	// Stage 3
	logic                     vld_s3;
	hsv2rgb_pkg::sector_t     sector_s3;
	logic [7:0]               val_s3;
	logic [7:0]               lo_s3;
	logic [23:0]              fall_num_s3;
	logic [23:0]              rise_num_s3;
	// Stage 4
	logic                     vld_s4;
	hsv2rgb_pkg::sector_t     sector_s4;
	logic [7:0]               val_s4;
	logic [7:0]               lo_s4;
	logic [15:0]              fall_mid_s4;
	logic [15:0]              rise_mid_s4;
	// Stage 5
	logic                     vld_s5;
	hsv2rgb_pkg::sector_t     sector_s5;
	logic [7:0]               val_s5;
	logic [7:0]               lo_s5;
	logic [7:0]               fall_s5;
	logic [7:0]               rise_s5;

	// Pipeline never stalls
	assign busy = 1'b0;
	assign take = start && !busy;

	// Stage 1: hue split
	hsv2rgb_hue_split u_hue_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (take),
		.hue      (hue),
		.vld_s1   (vld_s1),
		.split_s1 (split_s1)
	);

	always_ff @(posedge clk) begin
		sat_s1 <= saturation;
		val_s1 <= brightness;
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			done   <= vld_s5;
		end
	end

	// Stage 2: f*s, (255-f)*s, (255-s)*v
	always_ff @(posedge clk) begin
		sector_s2 <= split_s1.sector;
		val_s2    <= val_s1;
		fs_s2     <= {8'b0, split_s1.frac} * {8'b0, sat_s1};
		gs_s2     <= {8'b0, hsv2rgb_pkg::FULL_LEVEL - split_s1.frac} * {8'b0, sat_s1};
		ps_s2     <= {8'b0, hsv2rgb_pkg::FULL_LEVEL - sat_s1} * {8'b0, val_s1};
	end

	// Stage 3: scale by v, low level done
	always_ff @(posedge clk) begin
		sector_s3   <= sector_s2;
		val_s3      <= val_s2;
		lo_s3       <= 8'(hsv2rgb_pkg::div255({8'b0, ps_s2}));
		fall_num_s3 <= {8'b0, hsv2rgb_pkg::FULL_SQ - fs_s2} * {16'b0, val_s2};
		rise_num_s3 <= {8'b0, hsv2rgb_pkg::FULL_SQ - gs_s2} * {16'b0, val_s2};
	end

	// Stage 4: first divide by 255
	always_ff @(posedge clk) begin
		sector_s4   <= sector_s3;
		val_s4      <= val_s3;
		lo_s4       <= lo_s3;
		fall_mid_s4 <= 16'(hsv2rgb_pkg::div255(fall_num_s3));
		rise_mid_s4 <= 16'(hsv2rgb_pkg::div255(rise_num_s3));
	end

	// Stage 5: second divide by 255 (floor of floor is exact)
	always_ff @(posedge clk) begin
		sector_s5 <= sector_s4;
		val_s5    <= val_s4;
		lo_s5     <= lo_s4;
		fall_s5   <= 8'(hsv2rgb_pkg::div255({8'b0, fall_mid_s4}));
		rise_s5   <= 8'(hsv2rgb_pkg::div255({8'b0, rise_mid_s4}));
	end

	// Stage 6: place levels by sector
	always_ff @(posedge clk) begin
		case (sector_s5)
			hsv2rgb_pkg::SEC_RED_YELLOW: begin
				red <= val_s5;  green <= rise_s5; blue <= lo_s5;
			end
			hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
				red <= fall_s5; green <= val_s5;  blue <= lo_s5;
			end
			hsv2rgb_pkg::SEC_GREEN_CYAN: begin
				red <= lo_s5;   green <= val_s5;  blue <= rise_s5;
			end
			hsv2rgb_pkg::SEC_CYAN_BLUE: begin
				red <= lo_s5;   green <= fall_s5; blue <= val_s5;
			end
			hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
				red <= rise_s5; green <= lo_s5;   blue <= val_s5;
			end
			hsv2rgb_pkg::SEC_MAGENTA_RED: begin
				red <= val_s5;  green <= lo_s5;   blue <= fall_s5;
			end
			default: begin
				red <= val_s5;  green <= lo_s5;   blue <= fall_s5;
			end
		endcase
	end

	// Assertions

	// Fraction within a sector never exceeds 250
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (split_s1.frac <= 8'd250))
		else $error("hue fraction out of range");

	// One channel always carries the brightness
	a_val_placed: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |=> (red == $past(val_s5) || green == $past(val_s5)
			|| blue == $past(val_s5)))
		else $error("brightness missing from result");

	// No channel exceeds the brightness
	a_val_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |=> (red <= $past(val_s5) && green <= $past(val_s5)
			&& blue <= $past(val_s5)))
		else $error("channel above brightness");

endmodule
